// ===== src/kphs_pkg.sv =====
package kphs_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // one stored record, laid out as on the stream data bus
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] to;
    logic [31:0] from;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIFT_LD,
    ST_SIFT_LDW,
    ST_SIFT_CHK,
    ST_SIFT_CMP,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  function automatic logic key_less(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== src/keyed_pair_heap_sort.sv =====
// Load: one cycle per record while in_tready is high.
// Sort: each sift-down level issues the child reads, then compares and writes back;
//   the store reads are registered, so the compare follows the read issue.
// Emit: per record, read the store, load the output register, then hold until taken.
// Reset (rst_n low, synchronous): empty set, no overflow, no output beat pending.
module keyed_pair_heap_sort (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // payload_from[31:0], payload_to[63:32], sort_key[95:64]
  input  logic        in_tlast,   // last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // out_from[31:0], out_to[63:32], out_key[95:64]
  output logic        out_tlast,  // out_last
  output logic        out_tuser   // out_overflow
);
  import kphs_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             build_r, build_nxt;
  logic [IDX_W-1:0] top_r, top_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic [IDX_W-1:0] node_r, node_nxt;
  logic [IDX_W-1:0] emit_r, emit_nxt;
  rec_t             node_rec_r, node_rec_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  rec_t             mem [MAX_ITEMS];
  rec_t             rd_a_r, rd_b_r;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
  rec_t             wdata;

  logic             in_acc, out_acc, full;
  logic [CNT_W-1:0] n_after;
  logic [IDX_W:0]   kid_w;
  logic             kid_ok, right_ok, pick_b, go_down;
  rec_t             child;
  logic [IDX_W-1:0] child_idx;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_valid_r && out_tready;
  assign full     = (count_r == CNT_W'(MAX_ITEMS));
  assign n_after  = full ? count_r : count_r + 1'b1;

  assign kid_w     = {node_r, 1'b1};
  assign kid_ok    = kid_w <= {1'b0, last_r};
  assign right_ok  = kid_w < {1'b0, last_r};
  assign pick_b    = right_ok && key_less(rd_a_r.key, rd_b_r.key);
  assign child     = pick_b ? rd_b_r : rd_a_r;
  assign child_idx = pick_b ? kid_w[IDX_W-1:0] + 1'b1 : kid_w[IDX_W-1:0];
  assign go_down   = key_less(node_rec_r.key, child.key);

  // record store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tlast) begin
          state_nxt = (n_after < CNT_W'(2)) ? ST_EMIT_RD : ST_SIFT_LD;
        end
      end
      ST_SIFT_LD:  state_nxt = ST_SIFT_LDW;
      ST_SIFT_LDW: state_nxt = ST_SIFT_CHK;
      ST_SIFT_CHK, ST_SIFT_CMP: begin
        if (state_r == ST_SIFT_CHK && kid_ok) begin
          state_nxt = ST_SIFT_CMP;
        end else if (state_r == ST_SIFT_CMP && go_down) begin
          state_nxt = ST_SIFT_CHK;
        end else if (build_r) begin
          state_nxt = (top_r == '0) ? ST_SWAP_RD : ST_SIFT_LD;
        end else begin
          state_nxt = (last_r == '0) ? ST_EMIT_RD : ST_SWAP_RD;
        end
      end
      ST_SWAP_RD: state_nxt = ST_SWAP_WR;
      ST_SWAP_WR: state_nxt = ST_SIFT_CHK;
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_acc) begin
          state_nxt = out_last_r ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    build_nxt     = build_r;
    top_nxt       = top_r;
    last_nxt      = last_r;
    node_nxt      = node_r;
    emit_nxt      = emit_r;
    node_rec_nxt  = node_rec_r;
    out_rec_nxt   = out_rec_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    we            = 1'b0;
    waddr         = node_r;
    wdata         = node_rec_r;
    raddr_a       = '0;
    raddr_b       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            waddr     = count_r[IDX_W-1:0];
            wdata     = rec_t'(in_tdata);
            count_nxt = count_r + 1'b1;
          end
          if (in_tlast) begin
            last_nxt  = IDX_W'(n_after - 1'b1);
            top_nxt   = IDX_W'(n_after >> 1);
            build_nxt = 1'b1;
            emit_nxt  = '0;
          end
        end
      end
      ST_SIFT_LD: begin
        raddr_a = top_r;
      end
      ST_SIFT_LDW: begin
        node_rec_nxt = rd_a_r;
        node_nxt     = top_r;
      end
      ST_SIFT_CHK, ST_SIFT_CMP: begin
        if (state_r == ST_SIFT_CHK && kid_ok) begin
          raddr_a = kid_w[IDX_W-1:0];
          raddr_b = kid_w[IDX_W-1:0] + 1'b1;
        end else if (state_r == ST_SIFT_CMP && go_down) begin
          // move the larger child up, keep the sinking record in hand
          we       = 1'b1;
          wdata    = child;
          node_nxt = child_idx;
        end else begin
          // drop the sinking record into its final slot
          we = 1'b1;
          if (build_r) begin
            if (top_r == '0) begin
              build_nxt = 1'b0;
            end else begin
              top_nxt = top_r - 1'b1;
            end
          end
        end
      end
      ST_SWAP_RD: begin
        raddr_a = '0;
        raddr_b = last_r;
      end
      ST_SWAP_WR: begin
        // root goes to the end; old end sinks from the root
        we           = 1'b1;
        waddr        = last_r;
        wdata        = rd_a_r;
        node_rec_nxt = rd_b_r;
        node_nxt     = '0;
        last_nxt     = last_r - 1'b1;
      end
      ST_EMIT_RD: begin
        raddr_a = emit_r;
      end
      ST_EMIT_LD: begin
        out_rec_nxt   = rd_a_r;
        out_valid_nxt = 1'b1;
        out_last_nxt  = ((CNT_W'(emit_r) + 1'b1) == count_r);
        out_ovf_nxt   = dropped_r;
      end
      ST_EMIT_WAIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
          end else begin
            emit_nxt = emit_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      build_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      build_r     <= build_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r      <= top_nxt;
    last_r     <= last_nxt;
    node_r     <= node_nxt;
    emit_r     <= emit_nxt;
    node_rec_r <= node_rec_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rec_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

`ifndef SYNTHESIS
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while an output beat is pending");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("record count beyond capacity");

  a_node_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIFT_CHK) |-> (node_r <= last_r))
    else $error("sift node outside the heap");

  a_set_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (count_r == '0 && !dropped_r && in_tready))
    else $error("set not cleared after final beat");
`endif

endmodule
